// ----- rtl/lfd_pkg.sv -----
// Shared types, codes and constants of the LED fade dimmer.
package lfd_pkg;

    localparam logic [6:0] LEVEL_MAX = 7'd100;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_SET_TARGET = 3'd1;
    localparam logic [2:0] REQ_ADD_STEP   = 3'd2;
    localparam logic [2:0] REQ_ON         = 3'd3;
    localparam logic [2:0] REQ_OFF        = 3'd4;
    localparam logic [2:0] REQ_TOGGLE     = 3'd5;
    localparam logic [2:0] REQ_SET_NOW    = 3'd6;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_TOP       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_INTERVAL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_MIN    = 2'd3;

    // Reset values of the configuration registers and the state.
    localparam logic [15:0] PWM_TOP_RST       = 16'd999;
    localparam logic [14:0] FADE_STEP_RST     = 15'd96;
    localparam logic [15:0] TICK_INTERVAL_RST = 16'd8;
    localparam logic [6:0]  MEMORY_MIN_RST    = 7'd10;
    localparam logic [6:0]  MEMORY_LEVEL_RST  = 7'd70;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Gamma curve: rounding offset, and x / 10000 done as (x >> 4) / 625,
    // the latter as a multiplication by ceil(2^36 / 625) and a shift by 36,
    // exact for every dividend below 2^26.
    localparam logic [30:0] GAMMA_ROUND  = 31'd5000;
    localparam logic [26:0] DIV625_RECIP = 27'd109951163;
    localparam int          DIV625_SHIFT = 36;

    typedef logic [6:0] level_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        logic [2:0]        op;
        level_t            level;
        logic signed [7:0] step;
        logic [31:0]       now;
    } lfd_cmd_t;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [15:0] pwm_top;
        logic [14:0] fade_step_q8;
        logic [15:0] tick_interval_ms;
        level_t      memory_min_level;
    } lfd_cfg_t;

    function automatic level_t clamp_level(input logic [7:0] v);
        level_t r;
        if (v > {1'b0, LEVEL_MAX})
        begin
            r = LEVEL_MAX;
        end
        else
        begin
            r = v[6:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/lfd_if.sv -----
// Handshake interfaces for the request and result channels of the dimmer.
interface lfd_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [7:0]        req_level;
    logic signed [7:0] req_step;
    logic [31:0]       now_ms;

    modport source (output valid, output req_type, output req_level,
                    output req_step, output now_ms, input ready);
    modport sink   (input valid, input req_type, input req_level,
                    input req_step, input now_ms, output ready);
endinterface

interface lfd_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] pwm_compare;
    logic        pwm_write;
    logic [6:0]  current_level;
    logic [6:0]  target_level;
    logic [6:0]  memory_level;
    logic        lamp_on;

    modport source (output valid, output pwm_compare, output pwm_write,
                    output current_level, output target_level,
                    output memory_level, output lamp_on, input ready);
    modport sink   (input valid, input pwm_compare, input pwm_write,
                    input current_level, input target_level,
                    input memory_level, input lamp_on, output ready);
endinterface

// ----- rtl/led_fade_dimmer_gamma_pwm.sv -----
// Top level of the single-channel LED dimmer with fade ramp and gamma map.
//
// A dimmer for one LED channel. Each request word (tick, set target, add
// step, on, off, toggle or set now) yields exactly one result word holding
// the PWM compare value for the rounded present level, whether that word
// writes the compare, and the present, target and remembered levels. The
// front end checks and queues requests in a two-word command queue, so a
// new request is taken while the queue has room, even while the back end is
// busy or a result waits to be taken. The back end executes each command
// against the state, then makes three passes through its one shared
// multiplier (level squared, times the span pwm_top - 2, and the reciprocal
// multiply that divides by 10000), then adds two, caps at pwm_top and loads
// the output register. Time for fade ticks is taken from now_ms and compared
// with wrapping 32-bit arithmetic. The four configuration registers are
// written through cfg_write, cfg_index and cfg_data; the user must write
// them only while the block is idle, which the block does not enforce. A
// ramp that never reaches its target leaves the level where it is.
module led_fade_dimmer_gamma_pwm
    import lfd_pkg::*;
#(
    parameter int QUEUE_WORDS = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    lfd_req_if.sink                req,
    lfd_res_if.source              res
);

    logic [15:0] pwm_top_reg;
    logic [14:0] fade_step_reg;
    logic [15:0] tick_interval_reg;
    level_t      memory_min_reg;

    lfd_cfg_t    cfg;
    lfd_cmd_t    head;
    logic        head_valid;
    logic        head_pop;

    // Configuration registers; every index of the port maps to a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_top_reg       <= PWM_TOP_RST;
            fade_step_reg     <= FADE_STEP_RST;
            tick_interval_reg <= TICK_INTERVAL_RST;
            memory_min_reg    <= MEMORY_MIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PWM_TOP:       pwm_top_reg       <= cfg_data;
                CFG_FADE_STEP:     fade_step_reg     <= cfg_data[14:0];
                CFG_TICK_INTERVAL: tick_interval_reg <= cfg_data;
                CFG_MEMORY_MIN:    memory_min_reg    <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.pwm_top          = pwm_top_reg;
        cfg.fade_step_q8     = fade_step_reg;
        cfg.tick_interval_ms = tick_interval_reg;
        cfg.memory_min_level = memory_min_reg;
    end

    // Front end: request words are classified and queued.
    lfd_front #(
        .DEPTH (QUEUE_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    // Back end: state update, gamma map and the output register.
    lfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .res        (res)
    );

endmodule

// ----- rtl/lfd_front.sv -----
// Front end: takes request words, classifies them and queues the commands.
module lfd_front
    import lfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    lfd_req_if.sink     req,
    output lfd_cmd_t    head,
    output logic        head_valid,
    input  logic        head_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

    lfd_cmd_t         queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    lfd_cmd_t         cmd;
    logic             push;
    logic             pop;

    // Levels are clamped here so that the back end sees them in range.
    always_comb
    begin
        cmd.op    = req.req_type;
        cmd.level = clamp_level(req.req_level);
        cmd.step  = req.req_step;
        cmd.now   = req.now_ms;
    end

    assign req.ready  = (count_reg != FULL_COUNT);
    assign push       = req.valid && req.ready;
    assign head_valid = (count_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// ----- rtl/lfd_back.sv -----
// Back end: executes queued commands and maps the level to a PWM compare.
module lfd_back
    import lfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lfd_cfg_t    cfg,
    input  lfd_cmd_t    head,
    input  logic        head_valid,
    output logic        head_pop,
    lfd_res_if.source   res
);

    localparam logic [2:0] ST_EXEC   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_SPAN   = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]  state_reg, state_next;

    level_t      mem_reg, mem_next;
    level_t      goal_reg, goal_next;
    logic [14:0] q8_reg, q8_next;
    logic [31:0] last_reg, last_next;
    logic        write_reg, write_next;
    logic [53:0] product_reg;

    logic        res_valid_reg;
    logic [15:0] res_compare_reg;
    logic        res_write_reg;
    level_t      res_current_reg;
    level_t      res_target_reg;
    level_t      res_memory_reg;
    logic        res_lamp_reg;

    level_t             floor_lvl;
    level_t             mem_on;
    logic signed [8:0]  add_sum;
    level_t             add_lvl;
    level_t             set_lvl;
    logic [31:0]        elapsed;
    logic [14:0]        tq8;
    logic [14:0]        gap;
    logic               exec_go;

    logic [15:0] round_sum;
    level_t      lvl_round;
    logic [15:0] span;
    logic [30:0] biased;
    logic [26:0] mul_a, mul_b;
    logic [53:0] mul_p;
    logic [16:0] curve;
    logic [15:0] compare;
    logic        out_free;

    // ---------------------------------------------------------------
    // Command execution
    // ---------------------------------------------------------------
    assign floor_lvl = (cfg.memory_min_level > LEVEL_MAX) ? LEVEL_MAX
                                                           : cfg.memory_min_level;
    assign mem_on    = (mem_reg < floor_lvl) ? floor_lvl : mem_reg;
    assign add_sum   = $signed({2'b00, goal_reg}) + $signed({head.step[7], head.step});

    always_comb
    begin
        if (add_sum < 0)
        begin
            add_lvl = '0;
        end
        else if (add_sum > $signed({2'b00, LEVEL_MAX}))
        begin
            add_lvl = LEVEL_MAX;
        end
        else
        begin
            add_lvl = add_sum[6:0];
        end
    end

    assign set_lvl = (head.op == REQ_ADD_STEP) ? add_lvl : head.level;
    assign elapsed = head.now - last_reg;
    assign tq8     = {goal_reg, 8'h00};
    assign gap     = (q8_reg < tq8) ? (tq8 - q8_reg) : (q8_reg - tq8);
    assign exec_go = (state_reg == ST_EXEC) && head_valid;
    assign head_pop = exec_go;

    always_comb
    begin
        mem_next   = mem_reg;
        goal_next  = goal_reg;
        q8_next    = q8_reg;
        last_next  = last_reg;
        write_next = write_reg;
        if (exec_go)
        begin
            write_next = 1'b0;
            unique case (head.op)
                REQ_TICK:
                begin
                    if (elapsed >= {16'h0000, cfg.tick_interval_ms})
                    begin
                        last_next = head.now;
                        if (q8_reg != tq8)
                        begin
                            write_next = 1'b1;
                            if (gap <= cfg.fade_step_q8)
                            begin
                                q8_next = tq8;
                            end
                            else if (q8_reg < tq8)
                            begin
                                q8_next = q8_reg + cfg.fade_step_q8;
                            end
                            else
                            begin
                                q8_next = q8_reg - cfg.fade_step_q8;
                            end
                        end
                    end
                end
                REQ_SET_TARGET, REQ_ADD_STEP:
                begin
                    goal_next = set_lvl;
                    if (set_lvl > floor_lvl)
                    begin
                        mem_next = set_lvl;
                    end
                end
                REQ_ON:
                begin
                    mem_next  = mem_on;
                    goal_next = mem_on;
                end
                REQ_OFF:
                begin
                    goal_next = '0;
                end
                REQ_TOGGLE:
                begin
                    if (goal_reg == '0)
                    begin
                        mem_next  = mem_on;
                        goal_next = mem_on;
                    end
                    else
                    begin
                        goal_next = '0;
                    end
                end
                REQ_SET_NOW:
                begin
                    goal_next  = head.level;
                    q8_next    = {head.level, 8'h00};
                    write_next = 1'b1;
                    if (head.level > floor_lvl)
                    begin
                        mem_next = head.level;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Gamma map on one shared multiplier: L*L, then times the span,
    // then the reciprocal of 625 after the rounding offset and a shift.
    // ---------------------------------------------------------------
    assign round_sum = {1'b0, q8_reg} + 16'd128;
    assign lvl_round = round_sum[14:8];
    assign span      = (cfg.pwm_top >= 16'd2) ? (cfg.pwm_top - 16'd2) : '0;
    assign biased    = {1'b0, product_reg[29:0]} + GAMMA_ROUND;

    always_comb
    begin
        unique case (state_reg)
            ST_SQUARE:
            begin
                mul_a = {20'h00000, lvl_round};
                mul_b = {20'h00000, lvl_round};
            end
            ST_SPAN:
            begin
                mul_a = {13'h0000, product_reg[13:0]};
                mul_b = {11'h000, span};
            end
            ST_SCALE:
            begin
                mul_a = {1'b0, biased[29:4]};
                mul_b = DIV625_RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {27'h0, mul_a} * {27'h0, mul_b};

    assign curve = {1'b0, product_reg[DIV625_SHIFT+15:DIV625_SHIFT]} + 17'd2;

    always_comb
    begin
        if (lvl_round == '0)
        begin
            compare = '0;
        end
        else if (curve > {1'b0, cfg.pwm_top})
        begin
            compare = cfg.pwm_top;
        end
        else
        begin
            compare = curve[15:0];
        end
    end

    assign out_free = !res_valid_reg || res.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (head_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_SPAN;
            ST_SPAN:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_EXEC;
                end
            end
            default:   state_next = ST_EXEC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            mem_reg       <= MEMORY_LEVEL_RST;
            goal_reg      <= '0;
            q8_reg        <= '0;
            last_reg      <= '0;
            write_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mem_reg   <= mem_next;
            goal_reg  <= goal_next;
            q8_reg    <= q8_next;
            last_reg  <= last_next;
            write_reg <= write_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SQUARE) || (state_reg == ST_SPAN) || (state_reg == ST_SCALE))
        begin
            product_reg <= mul_p;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            res_compare_reg <= compare;
            res_write_reg   <= write_reg;
            res_current_reg <= lvl_round;
            res_target_reg  <= goal_reg;
            res_memory_reg  <= mem_reg;
            res_lamp_reg    <= (goal_reg != '0) || (q8_reg != '0);
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.pwm_compare   = res_compare_reg;
    assign res.pwm_write     = res_write_reg;
    assign res.current_level = res_current_reg;
    assign res.target_level  = res_target_reg;
    assign res.memory_level  = res_memory_reg;
    assign res.lamp_on       = res_lamp_reg;

endmodule
